FILE: hdl/f2m_pkg.sv
// ----------------------------------------------------------------------------
// f2m_pkg
// Constants shared by the single precision to minifloat converter.
// ----------------------------------------------------------------------------
package f2m_pkg;

   localparam int unsigned F32_WIDTH  = 32;
   localparam int unsigned MINI_WIDTH = 8;
   localparam logic [7:0]  EXP_REBIAS = 8'd120;
   localparam logic [6:0]  MINI_INF   = 7'h78;
   localparam logic [6:0]  MINI_NAN   = 7'h79;

endpackage

FILE: hdl/float32_to_minifloat_converter.sv
// an item goes from the input register to the result register or via the skid
// throughput: one item per cycle until the skid fills; an input register and
// a result register with a skid stage let an item enter while a result waits
// reset: synchronous active high, clears valid flags only
// ----------------------------------------------------------------------------
// float32_to_minifloat_converter
// Single precision to E4M3 minifloat, round to nearest even.
// ----------------------------------------------------------------------------
module float32_to_minifloat_converter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [f2m_pkg::F32_WIDTH-1:0]   req_float_bits,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [f2m_pkg::MINI_WIDTH-1:0]  rsp_mini_bits
);
   import f2m_pkg::*;

   logic                  in_vld_ff, in_vld_in;
   logic [F32_WIDTH-1:0]  in_dat_ff;
   logic                  out_vld_ff, out_vld_in;
   logic [MINI_WIDTH-1:0] out_dat_ff;
   logic                  skid_vld_ff, skid_vld_in;
   logic [MINI_WIDTH-1:0] skid_dat_ff;
   logic [MINI_WIDTH-1:0] conv;
   logic                  in_move;
   logic                  out_free;

   f2m_round u_round (.float_bits(in_dat_ff), .mini_bits(conv));

   assign out_free  = !out_vld_ff || !rsp_stall;
   // stall while the skid is full; input then moves only if output is free
   assign req_stall = skid_vld_ff;
   assign in_move   = in_vld_ff && (out_free || !skid_vld_ff);

   always_comb begin
      in_vld_in   = (req_valid && !req_stall) ? 1'b1 : (in_move ? 1'b0 : in_vld_ff);
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (out_free) begin
         out_vld_in  = skid_vld_ff || in_move;
         skid_vld_in = 1'b0;
      end else if (in_move) begin
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_dat_ff <= req_float_bits;
      if (out_free) begin
         out_dat_ff <= skid_vld_ff ? skid_dat_ff : conv;
         if (skid_vld_ff && in_move) skid_dat_ff <= conv;
      end else if (in_move) begin
         skid_dat_ff <= conv;
      end
      if (reset) begin
         in_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         in_vld_ff   <= in_vld_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in || (out_free && skid_vld_ff && in_move);
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_mini_bits = out_dat_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff) else $error("skid full with empty output");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !in_move) |=> in_vld_ff) else $error("item lost");

endmodule

FILE: hdl/f2m_round.sv
// ----------------------------------------------------------------------------
// f2m_round
// Combinational conversion of one single precision pattern to E4M3.
// ----------------------------------------------------------------------------
module f2m_round (
   input  logic [f2m_pkg::F32_WIDTH-1:0]  float_bits,
   output logic [f2m_pkg::MINI_WIDTH-1:0] mini_bits
);
   import f2m_pkg::*;

   logic        sign;
   logic [7:0]  efield;
   logic [22:0] man;
   logic [23:0] sig;
   logic [5:0]  sh;
   logic [3:0]  kept;
   logic        rbit;
   logic        sticky;
   logic [3:0]  q;
   logic [3:0]  exp_n;
   logic [3:0]  e_sum;

   assign sign   = float_bits[31];
   assign efield = float_bits[30:23];
   assign man    = float_bits[22:0];
   assign sig    = {efield != 8'd0, man};

   // right shift amount is 141 - efield for tiny values (32 below 109), 20 otherwise
   always_comb begin
      if (efield <= EXP_REBIAS) begin
         if (efield < 8'd109) sh = 6'd32;
         else sh = 6'(8'd141 - efield);
      end else begin
         sh = 6'd20;
      end
   end

   always_comb begin
      logic [23:0] s;
      s = (efield <= EXP_REBIAS) ? sig : {1'b0, man};
      if (sh >= 6'd25) begin
         kept   = '0;
         rbit   = 1'b0;
         sticky = |s;
      end else begin
         kept   = 4'(s >> sh);
         rbit   = s[5'(sh - 6'd1)];
         sticky = |(s & ((24'd1 << (sh - 6'd1)) - 24'd1));
      end
      q = kept + 4'(rbit & (sticky | kept[0]));
   end

   assign exp_n = 4'(efield - EXP_REBIAS);
   assign e_sum = exp_n + {3'd0, q[3]};

   always_comb begin
      if (efield >= 8'd135) begin
         mini_bits = {sign, (efield == 8'd255 && man != '0) ? MINI_NAN : MINI_INF};
      end else if (efield <= EXP_REBIAS) begin
         mini_bits = {sign, 3'b000, q};
      end else begin
         mini_bits = {sign, e_sum, q[2:0]};
      end
   end

endmodule

FILE: bench/tb_float32_to_minifloat_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_float32_to_minifloat_converter
// Drives single precision bit patterns into the converter and checks each
// minifloat item against a round-to-nearest-even predictor, under random
// idling on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_float32_to_minifloat_converter;
   import f2m_pkg::*;

   localparam int N_RANDOM    = 1800;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_DIRECTED  = 24;
   localparam logic [7:0] NO_EXPECT = 8'hff;  // 0xff is never a table answer

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_float_bits;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_mini_bits;

   logic [7:0]  expected_minis[$];
   int          n_errors = 0;
   int          n_table_errors = 0;
   int          n_checked = 0;
   int          cycle_count = 0;
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          hold_off;

   typedef struct {
      logic [31:0] bits;
      logic [7:0]  answer;
   } vector_type;

   vector_type directed[N_DIRECTED];

   float32_to_minifloat_converter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_float_bits(req_float_bits),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_mini_bits(rsp_mini_bits)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // shift right with round to nearest, ties to even
   function automatic logic [31:0] shift_round_even(logic [63:0] sig, int unsigned sh);
      logic [63:0] kept;
      logic [63:0] sticky;
      logic        rbit;
      if (sh > 40) sh = 40;
      kept   = sig >> sh;
      rbit   = sig[sh-1];
      sticky = sig & ((64'd1 << (sh - 1)) - 64'd1);
      if (rbit && (sticky != 0 || kept[0])) kept = kept + 64'd1;
      return kept[31:0];
   endfunction

   function automatic logic [7:0] to_minifloat(logic [31:0] bits);
      logic [7:0]  sign;
      logic [7:0]  efield;
      logic [22:0] man;
      logic [63:0] sig;
      logic [31:0] q;
      int          e;
      sign   = {bits[31], 7'd0};
      efield = bits[30:23];
      man    = bits[22:0];
      e      = int'(efield) - int'(EXP_REBIAS);
      if (e >= 15) begin
         return sign | ((efield == 8'hff && man != 0) ? {1'b0, MINI_NAN}
                                                      : {1'b0, MINI_INF});
      end else if (e <= 0) begin
         sig = {41'd0, man};
         if (efield != 0) sig[23] = 1'b1;
         q = shift_round_even(sig, 21 - e);
         return sign | q[7:0];
      end else begin
         q = shift_round_even({41'd0, man}, 20);
         return sign | 8'((e + int'(q >> 3)) << 3) | {5'd0, q[2:0]};
      end
   endfunction

   // half near the format's range, some ties or specials, the rest anything
   function automatic logic [31:0] random_float();
      logic [31:0] b;
      b = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: b[30:23] = 8'($urandom_range(115, 136));
         5: b[22:0] = {3'($urandom), 20'h80000 | (($urandom_range(0, 1)) ? 20'd0 : 20'($urandom))};
         6: b[30:23] = ($urandom_range(0, 1)) ? 8'hff : 8'h00;
         default: ;
      endcase
      return b;
   endfunction

   // valid stays high after an item so the next one can follow at once
   task automatic send_item(logic [31:0] bits);
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_float_bits <= bits;
      expected_minis.push_back(to_minifloat(bits));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver stall, random or held for a long stretch
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("Test completed with failures");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_minis.size() == 0) begin
            $display("%0t: unexpected item %h", $time, rsp_mini_bits);
            n_errors <= n_errors + 1;
         end else begin
            if (rsp_mini_bits !== expected_minis[0]) begin
               $display("%0t: mini_bits expected %h actual %h", $time,
                        expected_minis[0], rsp_mini_bits);
               n_errors <= n_errors + 1;
            end
            void'(expected_minis.pop_front());
            n_checked <= n_checked + 1;
         end
      end
   end

   initial begin
      int i;
      int phase;
      directed[0]  = '{32'h0000_0000, 8'h00};  // zero
      directed[1]  = '{32'h8000_0000, 8'h80};
      directed[2]  = '{32'h007f_ffff, 8'h00};  // input subnormal
      directed[3]  = '{32'h7f80_0000, 8'h78};  // infinity
      directed[4]  = '{32'hff80_0000, 8'hf8};
      directed[5]  = '{32'h7fc0_0000, 8'h79};  // nan keeps sign
      directed[6]  = '{32'hffff_ffff, 8'hf9};
      directed[7]  = '{32'h7f7f_ffff, 8'h78};  // too large
      directed[8]  = '{32'h4380_0000, 8'h78};  // exponent field 135
      directed[9]  = '{32'h3f80_0000, 8'h38};  // one
      directed[10] = '{32'h3c80_0000, 8'h08};  // smallest normal
      directed[11] = '{32'h3b00_0000, 8'h01};  // smallest subnormal
      directed[12] = '{32'h0080_0000, 8'h00};  // smallest normal input
      directed[13] = '{32'h4378_0000, 8'h78};  // 248: carry into infinity
      directed[14] = '{32'h4368_0000, 8'h76};  // 232 tie to even, rounds down
      directed[15] = '{32'h3f88_0000, NO_EXPECT};  // tie, even down
      directed[16] = '{32'h3f98_0000, NO_EXPECT};  // tie, odd up
      directed[17] = '{32'h3f88_0001, NO_EXPECT};  // sticky
      directed[18] = '{32'h3c7f_ffff, NO_EXPECT};  // subnormal carry to normal
      directed[19] = '{32'h3a80_0000, NO_EXPECT};  // half smallest subnormal tie
      directed[20] = '{32'h3a80_0001, NO_EXPECT};
      directed[21] = '{32'h3f7f_ffff, NO_EXPECT};  // carry into next exponent
      directed[22] = '{32'hbfff_ffff, NO_EXPECT};
      directed[23] = '{32'h3c00_0000, NO_EXPECT};
      reset = 1'b1;
      req_valid = 1'b0;
      req_float_bits = '0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_DIRECTED; i++) begin
         if (directed[i].answer != NO_EXPECT &&
             to_minifloat(directed[i].bits) != directed[i].answer) begin
            $display("%0t: table %h expected %h predictor %h", $time,
                     directed[i].bits, directed[i].answer, to_minifloat(directed[i].bits));
            n_table_errors++;
         end
         send_item(directed[i].bits);
      end

      // long receiver hold-off while items keep coming
      hold_off = 1'b1;
      fork
         begin
            repeat (40) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int k = 0; k < 20; k++) send_item(random_float());
      join
      // sender pauses until everything has drained
      req_valid <= 1'b0;
      while (expected_minis.size() != 0) @(negedge clock);

      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 69 : 0;
         recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 14 : 0;
         for (i = 0; i < N_RANDOM / 3; i++) send_item(random_float());
      end

      req_valid <= 1'b0;
      while (expected_minis.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("checked %0d converted items: signed zeros, subnormals, rounding ties,",
               n_checked);
      $display("carries, infinities and nans, under idling and a long output hold-off");
      if (n_errors == 0 && n_table_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: float32_to_minifloat_converter.f
hdl/f2m_pkg.sv
hdl/f2m_round.sv
hdl/float32_to_minifloat_converter.sv
bench/tb_float32_to_minifloat_converter.sv
